>>> src/hcb_pkg.sv
// ----------------------------------------------------------------------------
// Hill cipher block package
// Shared types, register codes and modulo-26 helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

	localparam int LETTER_W         = 5;
	localparam int KEY_W            = 45;
	localparam int CFG_W            = 45;
	localparam int ORDER            = 3;
	localparam int MAX_RESULTS      = 3;
	localparam int SUM_W            = 11;
	localparam int OUT_DEPTH_DEFAULT = 8;
	localparam int SETTLE_CYCLES    = 6;

	localparam logic [4:0]  MODULUS   = 5'd26;
	localparam logic [11:0] RECIP_26  = 12'd2521;  // ceil(2^16 / 26)
	localparam logic [4:0]  PAD_RESET = 5'd23;
	localparam logic [1:0]  BSIZE_RESET = 2'd3;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [ORDER-1:0][ORDER-1:0][LETTER_W-1:0] matrix_t;

	typedef enum logic [1:0] {
		REG_KEY        = 2'd0,
		REG_BLOCK_SIZE = 2'd1,
		REG_DECRYPT    = 2'd2,
		REG_PAD        = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [LETTER_W-1:0] letter_in;
		logic                message_end;
	} in_t;

	typedef struct packed {
		logic [LETTER_W-1:0] letter_out;
		logic                block_end;
		logic                key_error;
	} out_t;

	typedef struct packed {
		logic busy;
		logic invertible;
	} derive_status_t;

	// Reduce a 5-bit value (0..31) into 0..25.
	function automatic letter_t mod26_small(input logic [4:0] x);
		return (x >= MODULUS) ? letter_t'(x - MODULUS) : x;
	endfunction

	// Reduce an 11-bit value modulo 26 by a reciprocal multiply and one correction.
	function automatic letter_t mod26(input logic [SUM_W-1:0] x);
		logic [22:0] prod;
		logic [6:0]  q;
		logic [11:0] qm;
		logic [11:0] r;
		prod = {12'd0, x} * {11'd0, RECIP_26};
		q    = prod[22:16];
		qm   = {5'd0, q} * {7'd0, MODULUS};
		r    = {1'b0, x} - qm;
		if (r >= {7'd0, MODULUS}) begin
			r = r - {7'd0, MODULUS};
		end
		return r[4:0];
	endfunction

	// (a - b) mod 26 for a, b already in 0..25.
	function automatic letter_t sub26(input letter_t a, input letter_t b);
		return (a >= b) ? letter_t'(a - b) : letter_t'(a + MODULUS - b);
	endfunction

	function automatic letter_t neg26(input letter_t a);
		return (a == '0) ? '0 : letter_t'(MODULUS - a);
	endfunction

	// Inverse of a unit modulo 26; zero for a non-unit.
	function automatic letter_t unit_inverse(input letter_t d);
		letter_t r;
		case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Number of result words for one completed block.
	function automatic logic [1:0] block_words(input logic err, input logic n3);
		return err ? 2'd1 : (n3 ? 2'd3 : 2'd2);
	endfunction

endpackage

`default_nettype wire

>>> src/hcb_derive.sv
// ----------------------------------------------------------------------------
// Hill cipher key derivation
// Computes the applied matrix (key or its inverse modulo 26) over six
// pipeline stages that run from the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_derive (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       restart,
	input  wire [hcb_pkg::KEY_W-1:0]  key,
	input  wire                       n3,
	input  wire                       decrypt,
	output hcb_pkg::matrix_t          applied,
	output hcb_pkg::derive_status_t   status
);
	import hcb_pkg::*;

	localparam int CNT_W = $clog2(SETTLE_CYCLES + 1);

	logic [ORDER-1:0][ORDER-1:0][LETTER_W-1:0] k;
	logic [ORDER-1:0][ORDER-1:0][9:0]          pa_s1, pb_s1;
	matrix_t                                   cof_s2, cof_s3, cof_s4;
	logic [SUM_W-1:0]                          det_sum_s3;
	letter_t                                   dinv_s4;
	logic [ORDER-1:0][ORDER-1:0][9:0]          prod_s5;
	logic                                      inv_s5;
	matrix_t                                   adj;
	matrix_t                                   applied_q;
	logic                                      invertible_q;
	logic [CNT_W-1:0]                          settle_q;
	letter_t                                   det;

	always_comb begin
		for (int i = 0; i < ORDER; i++) begin
			for (int j = 0; j < ORDER; j++) begin
				k[i][j] = mod26_small(key[LETTER_W*(ORDER*i+j) +: LETTER_W]);
			end
		end
	end

	// The 2x2 determinant equals the 3x3 cofactor of the bottom-right entry.
	always_comb begin
		det = n3 ? mod26(det_sum_s3) : cof_s3[2][2];
	end

	always_comb begin
		adj = '0;
		if (n3) begin
			for (int i = 0; i < ORDER; i++) begin
				for (int j = 0; j < ORDER; j++) begin
					adj[i][j] = cof_s4[j][i];
				end
			end
		end else begin
			adj[0][0] = k[1][1];
			adj[0][1] = neg26(k[0][1]);
			adj[1][0] = neg26(k[1][0]);
			adj[1][1] = k[0][0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ORDER; i++) begin
			for (int j = 0; j < ORDER; j++) begin
				pa_s1[i][j] <= {5'd0, k[(i+1)%3][(j+1)%3]} * {5'd0, k[(i+2)%3][(j+2)%3]};
				pb_s1[i][j] <= {5'd0, k[(i+1)%3][(j+2)%3]} * {5'd0, k[(i+2)%3][(j+1)%3]};
				cof_s2[i][j] <= sub26(mod26({1'b0, pa_s1[i][j]}), mod26({1'b0, pb_s1[i][j]}));
				prod_s5[i][j] <= {5'd0, dinv_s4} * {5'd0, adj[i][j]};
				applied_q[i][j] <= decrypt ? (inv_s5 ? mod26({1'b0, prod_s5[i][j]}) : '0)
					: k[i][j];
			end
		end
		cof_s3     <= cof_s2;
		det_sum_s3 <= SUM_W'({5'd0, k[0][0]} * {5'd0, cof_s2[0][0]})
			+ SUM_W'({5'd0, k[0][1]} * {5'd0, cof_s2[0][1]})
			+ SUM_W'({5'd0, k[0][2]} * {5'd0, cof_s2[0][2]});
		cof_s4       <= cof_s3;
		dinv_s4      <= unit_inverse(det);
		inv_s5       <= (dinv_s4 != '0);
		invertible_q <= inv_s5;
	end

	// Inputs are held off until the stages have refilled from stable settings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= CNT_W'(SETTLE_CYCLES);
		end else if (restart) begin
			settle_q <= CNT_W'(SETTLE_CYCLES);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	assign applied           = applied_q;
	assign status.busy       = (settle_q != '0);
	assign status.invertible = invertible_q;

endmodule

`default_nettype wire

>>> src/hcb_result_fifo.sv
// ----------------------------------------------------------------------------
// Hill cipher result queue
// Takes up to three result words per cycle and delivers one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_result_fifo #(
	parameter int DEPTH = hcb_pkg::OUT_DEPTH_DEFAULT
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire [1:0]                                 push_n,
	input  hcb_pkg::out_t [hcb_pkg::MAX_RESULTS-1:0]  push_word,
	output logic                                      out_valid,
	input  wire                                       out_stall,
	output hcb_pkg::out_t                             out_word,
	output logic [$clog2(DEPTH+1)-1:0]                level
);
	import hcb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	out_t            mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [LW-1:0]   level_q;
	logic            pop;

	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [1:0] n);
		logic [AW+1:0] s;
		s = (AW+2)'(p) + (AW+2)'(n);
		if (s >= (AW+2)'(DEPTH)) begin
			s = s - (AW+2)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign pop       = out_valid && !out_stall;
	assign out_valid = (level_q != '0);
	assign out_word  = mem[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < push_n) begin
				mem[ptr_add(wr_ptr_q, 2'(i))] <= push_word[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= ptr_add(wr_ptr_q, push_n);
			if (pop) begin
				rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
			end
			level_q <= level_q + LW'(push_n) - LW'(pop);
		end
	end

endmodule

`default_nettype wire

>>> src/hill_cipher_block_top.sv
// Block words pass stages s1 and s2 and then the result queue. Throughput: one letter
// accepted per cycle while in_stall is low; words leave one per cycle, while out_stall
// is low, from an OUT_DEPTH-word queue, and input stalls when the queue could not take
// a whole block. Reset and every configuration write start a key derivation with
// in_stall high. Reset loads key 0, block size 3, encrypt mode and pad letter X.
// ----------------------------------------------------------------------------
// Hill cipher block, modulo 26
// Gathers letters into blocks of 2 or 3, pads short final blocks and
// multiplies each block by the key or its inverse modulo 26.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_cipher_block_top #(
	parameter int OUT_DEPTH = hcb_pkg::OUT_DEPTH_DEFAULT
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  hcb_pkg::in_t              in_word,
	output logic                      out_valid,
	input  wire                       out_stall,
	output hcb_pkg::out_t             out_word,
	input  wire                       cfg_write_en,
	input  wire [1:0]                 cfg_index,
	input  wire [hcb_pkg::CFG_W-1:0]  cfg_data
);
	import hcb_pkg::*;

	localparam int LW = $clog2(OUT_DEPTH + 1);

	// Configuration registers.
	logic [KEY_W-1:0] key_q;
	logic [1:0]       bsize_q;
	logic             decrypt_q;
	logic [4:0]       pad_q;
	logic             cfg_hit;

	// Block gathering.
	logic [1:0]       held_count_q;
	letter_t          held0_q, held1_q;

	// Pipeline.
	logic                          valid_s1, err_s1, n3_s1;
	letter_t [ORDER-1:0]           v_s1;
	logic                          valid_s2, err_s2, n3_s2;
	logic [ORDER-1:0][SUM_W-1:0]   sum_s2;

	matrix_t                       applied;
	derive_status_t                dstat;
	logic                          n3, in_accept, complete, err;
	letter_t                       letter, pad;
	letter_t [ORDER-1:0]           v;
	logic [1:0]                    words_s1, words_s2, push_n;
	out_t [MAX_RESULTS-1:0]        push_word;
	logic [LW-1:0]                 level;
	logic [LW+1:0]                 demand;

	assign n3      = (bsize_q == 2'd3);
	assign cfg_hit = cfg_write_en;

	hcb_derive u_derive (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_hit),
		.key     (key_q),
		.n3      (n3),
		.decrypt (decrypt_q),
		.applied (applied),
		.status  (dstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			bsize_q   <= BSIZE_RESET;
			decrypt_q <= 1'b0;
			pad_q     <= PAD_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_KEY:        key_q     <= cfg_data[KEY_W-1:0];
				REG_BLOCK_SIZE: bsize_q   <= cfg_data[1:0];
				REG_DECRYPT:    decrypt_q <= cfg_data[0];
				REG_PAD:        pad_q     <= cfg_data[4:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		letter   = mod26_small(in_word.letter_in);
		pad      = mod26_small(pad_q);
		complete = !((({1'b0, held_count_q} + 3'd1) < (n3 ? 3'd3 : 3'd2))
			&& !in_word.message_end);
		err      = decrypt_q && !dstat.invertible;
		case (held_count_q)
			2'd0:    v = {pad, pad, letter};
			2'd1:    v = {pad, letter, held0_q};
			default: v = {letter, held1_q, held0_q};
		endcase
		// Order 2 ignores the third column.
		if (!n3) begin
			v[2] = '0;
		end
	end

	// Worst case: every block in flight plus the next one lands in the queue.
	always_comb begin
		words_s1 = valid_s1 ? block_words(err_s1, n3_s1) : 2'd0;
		words_s2 = valid_s2 ? block_words(err_s2, n3_s2) : 2'd0;
		demand   = (LW+2)'(level) + (LW+2)'(words_s1) + (LW+2)'(words_s2)
			+ (LW+2)'(MAX_RESULTS);
		in_stall = dstat.busy || (demand > (LW+2)'(OUT_DEPTH));
	end

	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			valid_s1 <= in_accept && complete;
			valid_s2 <= valid_s1;
			if (cfg_hit) begin
				held_count_q <= '0;
			end else if (in_accept) begin
				held_count_q <= complete ? 2'd0 : held_count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && !complete) begin
			if (held_count_q[0]) begin
				held1_q <= letter;
			end else begin
				held0_q <= letter;
			end
		end
		v_s1   <= v;
		err_s1 <= err;
		n3_s1  <= n3;
		for (int i = 0; i < ORDER; i++) begin
			sum_s2[i] <= SUM_W'({5'd0, applied[i][0]} * {5'd0, v_s1[0]})
				+ SUM_W'({5'd0, applied[i][1]} * {5'd0, v_s1[1]})
				+ SUM_W'({5'd0, applied[i][2]} * {5'd0, v_s1[2]});
		end
		err_s2 <= err_s1;
		n3_s2  <= n3_s1;
	end

	always_comb begin
		push_n = words_s2;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			push_word[i].letter_out = mod26(sum_s2[i]);
			push_word[i].block_end  = n3_s2 ? (i == 2) : (i == 1);
			push_word[i].key_error  = 1'b0;
		end
		// A block decrypted with a singular key yields a single error word.
		if (err_s2) begin
			push_word[0].letter_out = '0;
			push_word[0].block_end  = 1'b1;
			push_word[0].key_error  = 1'b1;
		end
	end

	hcb_result_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_word (push_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.level     (level)
	);

endmodule

`default_nettype wire

>>> tb/sv/hcb_cipher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hill cipher block checker
// Watches the letter, word and register channels and keeps its own copy of
// the key, block size, mode and pad letter. It predicts the cipher words of
// every completed block and compares each word that leaves the block,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module hcb_cipher_checker (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire                       in_stall,
	input  hcb_pkg::in_t              in_word,
	input  wire                       out_valid,
	input  wire                       out_stall,
	input  hcb_pkg::out_t             out_word,
	input  wire                       cfg_write_en,
	input  wire [1:0]                 cfg_index,
	input  wire [hcb_pkg::CFG_W-1:0]  cfg_data,
	output int                        fail_count,
	output int                        pending_count
);

	import hcb_pkg::*;

	logic [KEY_W-1:0] cfg_key;
	logic [1:0]       cfg_bsize;
	logic             cfg_decrypt;
	logic [4:0]       cfg_pad;

	letter_t held [2];
	int      held_n;
	int      cipher_rows [3][3];
	bit      key_ok;
	out_t    cipher_words_due [$];
	int      errs = 0;

	function automatic int key_digit(input int r, input int c);
		return int'(cfg_key[5*(3*r+c) +: 5]) % 26;
	endfunction

	// Rebuild the matrix in use from the key, the order and the mode.
	function automatic void derive_cipher_rows();
		int k [3][3];
		int cof [3][3];
		int n;
		int det;
		int dinv;
		n = (cfg_bsize == 2'd3) ? 3 : 2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				k[i][j] = key_digit(i, j);
				cipher_rows[i][j] = 0;
			end
		end
		if (n == 3) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					cof[i][j] = k[(i+1)%3][(j+1)%3] * k[(i+2)%3][(j+2)%3]
						- k[(i+1)%3][(j+2)%3] * k[(i+2)%3][(j+1)%3];
					cof[i][j] = ((cof[i][j] % 26) + 26) % 26;
				end
			end
			det = (k[0][0] * cof[0][0] + k[0][1] * cof[0][1] + k[0][2] * cof[0][2]) % 26;
		end else begin
			cof[0][0] = k[1][1];
			cof[0][1] = (26 - k[1][0]) % 26;
			cof[1][0] = (26 - k[0][1]) % 26;
			cof[1][1] = k[0][0];
			det = (((k[0][0] * k[1][1] - k[0][1] * k[1][0]) % 26) + 26) % 26;
		end
		dinv = 0;
		for (int x = 1; x < 26; x++) begin
			if ((det * x) % 26 == 1) begin
				dinv = x;
			end
		end
		key_ok = (dinv != 0);
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				if (!cfg_decrypt) begin
					cipher_rows[i][j] = k[i][j];
				end else if (key_ok) begin
					cipher_rows[i][j] = (dinv * cof[j][i]) % 26;
				end
			end
		end
	endfunction

	// Take one letter; a full or ended block queues its cipher words.
	function automatic void gather_letter(input in_t w);
		int   n;
		int   v [3];
		int   have;
		int   acc;
		out_t r;
		n = (cfg_bsize == 2'd3) ? 3 : 2;
		if (held_n + 1 < n && !w.message_end) begin
			held[held_n] = letter_t'(int'(w.letter_in) % 26);
			held_n++;
			return;
		end
		have = 0;
		for (int i = 0; i < held_n; i++) begin
			v[have] = held[i];
			have++;
		end
		v[have] = int'(w.letter_in) % 26;
		have++;
		while (have < 3) begin
			v[have] = int'(cfg_pad) % 26;
			have++;
		end
		held_n = 0;
		if (cfg_decrypt && !key_ok) begin
			r.letter_out = '0;
			r.block_end  = 1'b1;
			r.key_error  = 1'b1;
			cipher_words_due.insert(cipher_words_due.size(), r);
			return;
		end
		for (int i = 0; i < n; i++) begin
			acc = 0;
			for (int j = 0; j < n; j++) begin
				acc += cipher_rows[i][j] * v[j];
			end
			r.letter_out = letter_t'(acc % 26);
			r.block_end  = (i == n - 1);
			r.key_error  = 1'b0;
			cipher_words_due.insert(cipher_words_due.size(), r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			cfg_key     = '0;
			cfg_bsize   = BSIZE_RESET;
			cfg_decrypt = 1'b0;
			cfg_pad     = PAD_RESET;
			held_n      = 0;
			cipher_words_due.delete();
			derive_cipher_rows();
		end else begin
			if (cfg_write_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_KEY:        cfg_key     = cfg_data[KEY_W-1:0];
					REG_BLOCK_SIZE: cfg_bsize   = cfg_data[1:0];
					REG_DECRYPT:    cfg_decrypt = cfg_data[0];
					REG_PAD:        cfg_pad     = cfg_data[4:0];
					default: ;
				endcase
				// Any write throws away a partly gathered block.
				held_n = 0;
				derive_cipher_rows();
			end
			if (in_valid && !in_stall) begin
				gather_letter(in_word);
			end
			if (out_valid && !out_stall) begin
				if (cipher_words_due.size() == 0) begin
					errs++;
					$display("%0t: unexpected word, expected none, actual letter %0d end %0b err %0b",
						$time, out_word.letter_out, out_word.block_end, out_word.key_error);
				end else begin
					want = cipher_words_due.pop_front();
					if (out_word.letter_out !== want.letter_out) begin
						errs++;
						$display("%0t: letter_out expected %0d actual %0d",
							$time, want.letter_out, out_word.letter_out);
					end
					if (out_word.block_end !== want.block_end) begin
						errs++;
						$display("%0t: block_end expected %0b actual %0b",
							$time, want.block_end, out_word.block_end);
					end
					if (out_word.key_error !== want.key_error) begin
						errs++;
						$display("%0t: key_error expected %0b actual %0b",
							$time, want.key_error, out_word.key_error);
					end
				end
			end
		end
		pending_count <= cipher_words_due.size();
		fail_count    <= errs;
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hill cipher block testbench
// Drives letter streams through a series of key, block size, mode and pad
// settings, with random idle cycles on both channels, one long output
// hold-off and a watchdog, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb_top;

	import hcb_pkg::*;

	localparam int SETTLE     = 12;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES     = 16;
	localparam int PHASE_LEN  = 30;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	in_t              in_word      = '0;
	logic             out_stall    = 1'b0;
	logic             cfg_write_en = 1'b0;
	logic [1:0]       cfg_index    = '0;
	logic [CFG_W-1:0] cfg_data     = '0;
	wire              in_stall;
	wire              out_valid;
	out_t             out_word;
	int               fail_count;
	int               pending_count;

	logic calm     = 1'b0;
	logic hold_req = 1'b0;
	bit   hold_taken = 1'b0;
	int   hold_left  = 0;
	int   idle_cycles = 0;

	always #1 clk = ~clk;

	hill_cipher_block_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_word      (in_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_word     (out_word),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	hcb_cipher_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_word       (in_word),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_word      (out_word),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Receiver: random stalls, plus one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 14);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Entry r,c of the key sits at bit 5*(3r+c).
	function automatic logic [KEY_W-1:0] key_of(
		input int k00, k01, k02, k10, k11, k12, k20, k21, k22);
		return {5'(k22), 5'(k21), 5'(k20), 5'(k12), 5'(k11), 5'(k10),
			5'(k02), 5'(k01), 5'(k00)};
	endfunction

	task automatic offer_letter(input logic [4:0] letter, input logic last);
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word.letter_in   <= letter;
		in_word.message_end <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted word has left the block.
	// The first edge lets the count take in the last accepted letter.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_config(input logic [KEY_W-1:0] key, input logic [1:0] bsize,
		input logic decrypt, input logic [4:0] pad);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'({$urandom, $urandom});
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_KEY;
		cfg_data     <= key;
		@(posedge clk);
		cfg_index    <= REG_BLOCK_SIZE;
		cfg_data     <= {junk[CFG_W-1:2], bsize};
		@(posedge clk);
		cfg_index    <= REG_DECRYPT;
		cfg_data     <= {junk[CFG_W-1:1], decrypt};
		@(posedge clk);
		cfg_index    <= REG_PAD;
		cfg_data     <= {junk[CFG_W-1:5], pad};
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [KEY_W-1:0] key;
		logic [1:0]       bsize;
		logic             decrypt;
		logic [4:0]       pad;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero key, order 3, pad X; out-of-range letters too.
		offer_letter(5'd0, 1'b0);
		offer_letter(5'd25, 1'b0);
		offer_letter(5'd31, 1'b1);
		offer_letter(5'd26, 1'b1);
		drain_block();

		// Invertible order-3 key, encrypting, pad out of range.
		load_config(key_of(6, 24, 1, 13, 16, 10, 20, 17, 15), 2'd3, 1'b0, 5'd31);
		offer_letter(5'd0, 1'b0);
		offer_letter(5'd2, 1'b0);
		offer_letter(5'd19, 1'b0);
		offer_letter(5'd25, 1'b1);
		offer_letter(5'd26, 1'b0);
		offer_letter(5'd31, 1'b1);
		drain_block();

		// Same key, decrypting.
		load_config(key_of(6, 24, 1, 13, 16, 10, 20, 17, 15), 2'd3, 1'b1, 5'd25);
		offer_letter(5'd15, 1'b0);
		offer_letter(5'd14, 1'b0);
		offer_letter(5'd7, 1'b0);
		offer_letter(5'd4, 1'b1);
		drain_block();

		// Order 2 decrypting; unused key entries hold 31.
		load_config(key_of(3, 3, 31, 2, 5, 31, 31, 31, 31), 2'd2, 1'b1, 5'd0);
		offer_letter(5'd7, 1'b0);
		offer_letter(5'd8, 1'b0);
		offer_letter(5'd30, 1'b1);
		offer_letter(5'd1, 1'b0);
		drain_block();

		// A key with no inverse while decrypting; the held letter is dropped
		// by the next write.
		load_config(key_of(31, 31, 31, 31, 31, 31, 31, 31, 31), 2'd3, 1'b1, 5'd23);
		offer_letter(5'd1, 1'b0);
		offer_letter(5'd2, 1'b1);
		offer_letter(5'd3, 1'b0);
		drain_block();

		for (int p = 0; p < PHASES; p++) begin
			key     = KEY_W'({$urandom, $urandom});
			bsize   = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
			decrypt = 1'($urandom_range(0, 1));
			pad     = 5'($urandom_range(0, 31));
			case (p)
				0: begin
					key = '1;
					pad = 5'd0;
				end
				1: begin
					key     = '0;
					decrypt = 1'b1;
				end
				2: pad = 5'd31;
				3: pad = 5'd25;
				default: if ($urandom_range(0, 3) == 0) key = '1;
			endcase
			load_config(key, bsize, decrypt, pad);
			calm <= (p == 5);
			if (p == 8) begin
				hold_req <= 1'b1;
			end
			for (int i = 0; i < PHASE_LEN; i++) begin
				offer_letter(5'($urandom_range(0, 31)), $urandom_range(0, 99) < 20);
			end
			drain_block();
		end

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
